// ===== sv/sap_pkg.sv =====
package sap_pkg;

    typedef enum logic [3:0] {
        PH_FLAGS   = 4'd0,
        PH_SIZE    = 4'd1,
        PH_UID     = 4'd2,
        PH_GID     = 4'd3,
        PH_PERMS   = 4'd4,
        PH_ATIME   = 4'd5,
        PH_MTIME   = 4'd6,
        PH_EXTCNT  = 4'd7,
        PH_STRLEN  = 4'd8,
        PH_STRBODY = 4'd9,
        PH_DONE    = 4'd15
    } phase_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TRUNC   = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

    localparam logic [31:0] FL_SIZE  = 32'h0000_0001;
    localparam logic [31:0] FL_OWNER = 32'h0000_0002;
    localparam logic [31:0] FL_PERMS = 32'h0000_0004;
    localparam logic [31:0] FL_TIMES = 32'h0000_0008;
    localparam logic [31:0] FL_EXT   = 32'h8000_0000;
    localparam logic [31:0] FL_KNOWN = FL_SIZE | FL_OWNER | FL_PERMS | FL_TIMES | FL_EXT;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } beat_t;

    typedef struct packed {
        logic [31:0] modify_time;
        logic [31:0] access_time;
        logic [31:0] permissions;
        logic [31:0] group_gid;
        logic [31:0] owner_uid;
        logic [63:0] file_size;
        logic        has_times;
        logic        perms_present;
        logic        has_owner;
        logic        size_present;
        logic [1:0]  status;
    } result_t;

endpackage

// ===== sv/sap_in_stage.sv =====
module sap_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_valid,
    output logic           s_ready,
    input  sap_pkg::beat_t s_beat,
    output logic           beat_valid,
    output sap_pkg::beat_t beat,
    input  logic           advance
);

    logic           valid_reg;
    logic           valid_next;
    sap_pkg::beat_t beat_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ===== sv/sap_parse.sv =====
module sap_parse
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  sap_pkg::beat_t   beat,
    output logic             res_valid,
    output sap_pkg::result_t res
);

    sap_pkg::phase_t phase_reg, phase_next;
    logic [31:0]     flags_reg, flags_next;
    logic [2:0]      idx_reg, idx_next;
    logic [63:0]     shift_reg, shift_next;
    logic [31:0]     pairs_reg, pairs_next;
    logic [31:0]     sbl_reg, sbl_next;
    logic            second_reg, second_next;
    logic [63:0]     size_reg, size_next;
    logic [31:0]     uid_reg, uid_next;
    logic [31:0]     gid_reg, gid_next;
    logic [31:0]     perms_reg, perms_next;
    logic [31:0]     atime_reg, atime_next;
    logic [31:0]     mtime_reg, mtime_next;

    function automatic sap_pkg::phase_t next_after(sap_pkg::phase_t p, logic [31:0] fl);
        sap_pkg::phase_t n;
        begin
            n = sap_pkg::PH_DONE;
            if (p < sap_pkg::PH_SIZE && (fl & sap_pkg::FL_SIZE) != '0)
                n = sap_pkg::PH_SIZE;
            else if (p < sap_pkg::PH_UID && (fl & sap_pkg::FL_OWNER) != '0)
                n = sap_pkg::PH_UID;
            else if (p == sap_pkg::PH_UID)
                n = sap_pkg::PH_GID;
            else if (p < sap_pkg::PH_PERMS && (fl & sap_pkg::FL_PERMS) != '0)
                n = sap_pkg::PH_PERMS;
            else if (p < sap_pkg::PH_ATIME && (fl & sap_pkg::FL_TIMES) != '0)
                n = sap_pkg::PH_ATIME;
            else if (p == sap_pkg::PH_ATIME)
                n = sap_pkg::PH_MTIME;
            else if (p < sap_pkg::PH_EXTCNT && (fl & sap_pkg::FL_EXT) != '0)
                n = sap_pkg::PH_EXTCNT;
            return n;
        end
    endfunction

    always_comb
    begin
        sap_pkg::phase_t ph;
        sap_pkg::phase_t nxt;
        sap_pkg::phase_t sf_phase;
        logic            sf_second;
        logic [31:0]     sf_pairs;
        logic [63:0]     acc;
        logic [3:0]      idx_inc;
        logic [3:0]      need;
        logic [31:0]     sbl_dec;

        phase_next  = phase_reg;
        flags_next  = flags_reg;
        idx_next    = idx_reg;
        shift_next  = shift_reg;
        pairs_next  = pairs_reg;
        sbl_next    = sbl_reg;
        second_next = second_reg;
        size_next   = size_reg;
        uid_next    = uid_reg;
        gid_next    = gid_reg;
        perms_next  = perms_reg;
        atime_next  = atime_reg;
        mtime_next  = mtime_reg;
        res_valid   = 1'b0;
        res         = '0;

        ph = (phase_reg > sap_pkg::PH_STRBODY) ? sap_pkg::PH_FLAGS : phase_reg;
        nxt = ph;

        // end of one string of a pair
        if (!second_reg)
        begin
            sf_second = 1'b1;
            sf_pairs  = pairs_reg;
            sf_phase  = sap_pkg::PH_STRLEN;
        end
        else
        begin
            sf_second = 1'b0;
            sf_pairs  = pairs_reg - 32'd1;
            sf_phase  = (sf_pairs == '0) ? sap_pkg::PH_DONE : sap_pkg::PH_STRLEN;
        end

        acc     = {shift_reg[55:0], beat.data_byte};
        idx_inc = {1'b0, idx_reg} + 4'd1;
        need    = (ph == sap_pkg::PH_SIZE) ? 4'd8 : 4'd4;
        sbl_dec = sbl_reg - 32'd1;

        if (ph == sap_pkg::PH_STRBODY)
        begin
            sbl_next = sbl_dec;
            if (sbl_dec == '0)
            begin
                second_next = sf_second;
                pairs_next  = sf_pairs;
                nxt         = sf_phase;
            end
        end
        else if (idx_inc < need)
        begin
            idx_next   = idx_inc[2:0];
            shift_next = acc;
        end
        else
        begin
            idx_next   = '0;
            shift_next = '0;
            case (ph)
                sap_pkg::PH_SIZE:
                begin
                    size_next = acc;
                    nxt = next_after(ph, flags_reg);
                end
                sap_pkg::PH_UID:
                begin
                    uid_next = acc[31:0];
                    nxt = next_after(ph, flags_reg);
                end
                sap_pkg::PH_GID:
                begin
                    gid_next = acc[31:0];
                    nxt = next_after(ph, flags_reg);
                end
                sap_pkg::PH_PERMS:
                begin
                    perms_next = acc[31:0];
                    nxt = next_after(ph, flags_reg);
                end
                sap_pkg::PH_ATIME:
                begin
                    atime_next = acc[31:0];
                    nxt = next_after(ph, flags_reg);
                end
                sap_pkg::PH_MTIME:
                begin
                    mtime_next = acc[31:0];
                    nxt = next_after(ph, flags_reg);
                end
                sap_pkg::PH_EXTCNT:
                begin
                    pairs_next  = acc[31:0];
                    second_next = 1'b0;
                    nxt = (acc[31:0] == '0) ? sap_pkg::PH_DONE : sap_pkg::PH_STRLEN;
                end
                sap_pkg::PH_STRLEN:
                begin
                    sbl_next = acc[31:0];
                    if (acc[31:0] == '0)
                    begin
                        second_next = sf_second;
                        pairs_next  = sf_pairs;
                        nxt         = sf_phase;
                    end
                    else
                    begin
                        nxt = sap_pkg::PH_STRBODY;
                    end
                end
                default:
                begin
                    flags_next = acc[31:0];
                    nxt = next_after(sap_pkg::PH_FLAGS, acc[31:0]);
                end
            endcase
        end

        if (nxt == sap_pkg::PH_DONE || beat.end_of_buffer)
        begin
            res_valid = 1'b1;
            if (nxt == sap_pkg::PH_DONE)
            begin
                res.status        = ((flags_next & ~sap_pkg::FL_KNOWN) != '0) ?
                                    sap_pkg::STATUS_UNKNOWN : sap_pkg::STATUS_OK;
                res.size_present  = flags_next[0];
                res.has_owner     = flags_next[1];
                res.perms_present = flags_next[2];
                res.has_times     = flags_next[3];
                res.file_size     = size_next;
                res.owner_uid     = uid_next;
                res.group_gid     = gid_next;
                res.permissions   = perms_next;
                res.access_time   = atime_next;
                res.modify_time   = mtime_next;
            end
            else
            begin
                res.status = sap_pkg::STATUS_TRUNC;
            end
            phase_next  = sap_pkg::PH_FLAGS;
            flags_next  = '0;
            idx_next    = '0;
            shift_next  = '0;
            pairs_next  = '0;
            sbl_next    = '0;
            second_next = 1'b0;
            size_next   = '0;
            uid_next    = '0;
            gid_next    = '0;
            perms_next  = '0;
            atime_next  = '0;
            mtime_next  = '0;
        end
        else
        begin
            phase_next = nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= sap_pkg::PH_FLAGS;
            flags_reg  <= '0;
            idx_reg    <= '0;
            shift_reg  <= '0;
            pairs_reg  <= '0;
            sbl_reg    <= '0;
            second_reg <= 1'b0;
            size_reg   <= '0;
            uid_reg    <= '0;
            gid_reg    <= '0;
            perms_reg  <= '0;
            atime_reg  <= '0;
            mtime_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            flags_reg  <= flags_next;
            idx_reg    <= idx_next;
            shift_reg  <= shift_next;
            pairs_reg  <= pairs_next;
            sbl_reg    <= sbl_next;
            second_reg <= second_next;
            size_reg   <= size_next;
            uid_reg    <= uid_next;
            gid_reg    <= gid_next;
            perms_reg  <= perms_next;
            atime_reg  <= atime_next;
            mtime_reg  <= mtime_next;
        end
    end

endmodule

// ===== sv/sap_out_stage.sv =====
module sap_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             res_valid,
    input  sap_pkg::result_t res,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output sap_pkg::result_t m_res
);

    logic             valid_reg;
    logic             valid_next;
    logic             load;
    sap_pkg::result_t res_reg;

    assign free       = !valid_reg || m_ready;
    assign load       = advance && res_valid;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== sv/sftp_attrs_parser.sv =====
// SFTP v3 ATTRS record parser.
// Slave stream: one buffer byte per beat on s_axis_tdata; s_axis_tlast marks
// the last byte available in the buffer.
// Master stream: one beat per finished record or per truncated record.
// m_axis_tuser carries status (0 ok, 1 truncated, 2 unknown flag bits) and
// the presence bits; m_axis_tdata carries the field values, zero when absent.
// A truncated record reports all presence bits and values as zero.
// A byte accepted from s_axis lands in the input register; the phase machine
// parses it from there and, if it ends a record, loads the result into the
// result register that drives m_axis. The phase machine takes one byte per
// cycle while m_axis is not stalled, between the input and result registers.
// When m_axis is stalled with a result held, parsing pauses and s_axis_tready
// drops once the input register is full; nothing is lost.
// Reset clears both stream valids and returns the parser to the start of a
// flag word.
module sftp_attrs_parser
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tlast,   // end_of_buffer
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [223:0] m_axis_tdata,   // file_size, owner_uid, group_gid,
                                         // permissions, access_time, modify_time
    output logic [5:0]   m_axis_tuser    // status[1:0], size present, owner present,
                                         // perms present, times present
);

    sap_pkg::beat_t   s_beat;
    sap_pkg::beat_t   beat;
    logic             beat_valid;
    logic             advance;
    logic             out_free;
    logic             res_valid;
    sap_pkg::result_t res;
    sap_pkg::result_t m_res;

    assign s_beat.data_byte     = s_axis_tdata;
    assign s_beat.end_of_buffer = s_axis_tlast;
    assign advance = beat_valid && out_free;

    sap_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_beat     (s_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .advance    (advance)
    );

    sap_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    sap_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_res     (m_res)
    );

    assign m_axis_tdata = {m_res.modify_time, m_res.access_time, m_res.permissions,
                           m_res.group_gid, m_res.owner_uid, m_res.file_size};
    assign m_axis_tuser = {m_res.has_times, m_res.perms_present, m_res.has_owner,
                           m_res.size_present, m_res.status};

endmodule

// ===== sv/sap_checker.sv =====
module sap_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [223:0] m_axis_tdata,
    input logic [5:0]   m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[1:0] <= sap_pkg::STATUS_UNKNOWN)
        else $error("undefined status code");

    a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == sap_pkg::STATUS_TRUNC |->
            m_axis_tuser[5:2] == '0 && m_axis_tdata == '0)
        else $error("truncated record carries data");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[63:0] == '0)
        else $error("absent size is nonzero");

endmodule

bind sftp_attrs_parser sap_checker u_sap_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
